// File: sv/ssw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_pkg: shared types and constants for the seven-segment serial writer
// Frame request passed from the sequencer to the shifter, and the digit and
// position code tables.
// ----------------------------------------------------------------------------
package ssw_pkg;

    localparam int NUM_W   = 32;   // width of the input number
    localparam int PROD_W  = 64;   // width of the reciprocal product
    localparam int REM_W   = 4;    // decimal digit
    localparam int POS_W   = 3;    // display position, up to eight positions
    localparam int FRAME_W = 16;   // segment byte then select byte
    localparam int BCNT_W  = 4;    // bit counter within one frame

    localparam logic [REM_W-1:0] DIVISOR = 4'd10;

    // ceil(2^35 / 10): exact quotient for every 32-bit dividend after >> 35
    localparam logic [NUM_W-1:0] RECIP_10    = 32'hCCCCCCCD;
    localparam int               RECIP_SHIFT = 35;

    // frame request from sequencer to shifter
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [1:0]         pos;
        logic               is_last;
    } t_frame_req;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DRAIN
    } t_seq_state;

    // active-low segment byte for one decimal digit
    function automatic logic [7:0] seg_code(input logic [REM_W-1:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hFF;
        endcase
        return code;
    endfunction

    // position select byte; positions above three enable nothing
    function automatic logic [7:0] sel_code(input logic [POS_W-1:0] pos);
        logic [7:0] code;
        unique case (pos)
            3'd0:    code = 8'hF1;
            3'd1:    code = 8'hF2;
            3'd2:    code = 8'hF4;
            3'd3:    code = 8'hF8;
            default: code = 8'hF0;
        endcase
        return code;
    endfunction

endpackage

// File: sv/ssw_div10.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_div10: divide by ten
// Reciprocal multiplication in two steps: the scaled product first, then
// quotient and remainder. Both hold after the second step until the next start.
// ----------------------------------------------------------------------------
module ssw_div10 (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ssw_pkg::NUM_W-1:0] i_dividend,
    output logic                      o_busy,
    output logic [ssw_pkg::NUM_W-1:0] o_quotient,
    output logic [ssw_pkg::REM_W-1:0] o_remainder
);
    import ssw_pkg::*;

    logic              r_busy;
    logic              r_step;
    logic [NUM_W-1:0]  r_num;
    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  r_q;
    logic [REM_W-1:0]  r_rem;

    logic [NUM_W-1:0]  quot;

    // quotient from the scaled product
    assign quot = NUM_W'(r_prod >> RECIP_SHIFT);

    // control: product step, then result step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 1'b0;
        end else if (r_busy) begin
            r_step <= 1'b1;
            if (r_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    // dividend, product, quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
        end else if (r_busy && !r_step) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(RECIP_10);
        end else if (r_busy) begin
            r_q   <= quot;
            // remainder is below ten, so the low four bits are enough
            r_rem <= r_num[REM_W-1:0] - quot[REM_W-1:0] * DIVISOR;
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

// File: sv/ssw_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_shifter: frame serialiser
// Holds one 16-bit frame and presents it MSB first, one bit per beat, with
// frame end and last flags on the final bit.
// ----------------------------------------------------------------------------
module ssw_shifter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ssw_pkg::t_frame_req i_req,
    output logic                o_busy,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_serial_bit,
    output logic [1:0]          o_digit_position,
    output logic                o_frame_end,
    output logic                o_last
);
    import ssw_pkg::*;

    logic               r_busy;
    logic [BCNT_W-1:0]  r_cnt;
    logic [FRAME_W-1:0] r_frame;
    logic [1:0]         r_pos;
    logic               r_is_last;
    logic               fend;

    assign fend = (r_cnt == BCNT_W'(FRAME_W - 1));

    // beat control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy && !i_stall) begin
            r_cnt <= r_cnt + 1'b1;
            if (fend) begin
                r_busy <= 1'b0;
            end
        end
    end

    // frame shift register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame   <= i_req.frame;
            r_pos     <= i_req.pos;
            r_is_last <= i_req.is_last;
        end else if (r_busy && !i_stall) begin
            r_frame <= {r_frame[FRAME_W-2:0], 1'b0};
        end
    end

    assign o_busy           = r_busy;
    assign o_valid          = r_busy;
    assign o_serial_bit     = r_frame[FRAME_W-1];
    assign o_digit_position = r_pos;
    assign o_frame_end      = fend;
    assign o_last           = fend && r_is_last;

endmodule

// File: sv/seven_segment_serial_writer.sv
`timescale 1ns / 1ps
// After a number is accepted, the divider forms the product, then the quotient
// and remainder, and the shifter then loads the first frame and presents its first
// beat. Each later digit is divided in the shared divide-by-ten unit, hidden behind
// the 16-beat frame of the previous digit; a frame is loaded only once the shifter
// is free, and a new number is accepted only once the last frame has left.
// Reset: synchronous, active low; clears sequencer, divider and shifter control.
// ----------------------------------------------------------------------------
// seven_segment_serial_writer: serial frame writer for a seven-segment display
// Splits a number into decimal digits, least significant first, and sends
// one segment/select frame per digit, up to DIGIT_COUNT digits, one bit per beat.
// ----------------------------------------------------------------------------
module seven_segment_serial_writer #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [ssw_pkg::NUM_W-1:0] i_number,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_serial_bit,
    output logic [1:0]                o_digit_position,
    output logic                      o_frame_end,
    output logic                      o_last
);
    import ssw_pkg::*;

    t_seq_state       r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;

    logic             div_start;
    logic [NUM_W-1:0] div_in;
    logic             div_busy;
    logic [NUM_W-1:0] div_quot;
    logic [REM_W-1:0] div_rem;

    logic             sh_load;
    logic             sh_busy;
    t_frame_req       sh_req;
    logic             more;

    // shared divide-by-ten unit
    ssw_div10 u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_in),
        .o_busy      (div_busy),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    // frame serialiser
    ssw_shifter u_shift (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (sh_load),
        .i_req            (sh_req),
        .o_busy           (sh_busy),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_serial_bit     (o_serial_bit),
        .o_digit_position (o_digit_position),
        .o_frame_end      (o_frame_end),
        .o_last           (o_last)
    );

    // another digit follows while higher digits remain and positions are left
    assign more = (div_quot != '0) && (r_pos != '0);

    // frame for the digit just divided out
    always_comb begin
        sh_req.frame   = {seg_code(div_rem), sel_code(r_pos)};
        sh_req.pos     = r_pos[1:0];
        sh_req.is_last = !more;
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        div_start = 1'b0;
        div_in    = div_quot;
        sh_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    div_start = 1'b1;
                    div_in    = i_number;
                    n_pos     = POS_W'(DIGIT_COUNT - 1);
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_busy && !sh_busy) begin
                    sh_load = 1'b1;
                    if (more) begin
                        div_start = 1'b1;
                        n_pos     = r_pos - 1'b1;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!sh_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    // checks
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> div_busy)
        else $error("divider not started after accepted number");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sh_load |-> (!sh_busy && !div_busy))
        else $error("frame loaded while shifter or divider busy");

    a_last_on_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_frame_end)
        else $error("last flag away from frame end");

    a_drain_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> !div_busy)
        else $error("divider running while draining final frame");

endmodule

// File: tb/seven_segment_serial_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_serial_writer_test: self-checking bench for the serial writer
// Feeds numbers through the valid/stall input channel and predicts every
// serial beat (data bit, position, frame end, last) from the decimal digits.
// Directed numbers come first, then random ones under three idling regimes.
// ----------------------------------------------------------------------------
module seven_segment_serial_writer_test;

    localparam int DISPLAY_DIGITS = 4;
    localparam int FRAME_BITS     = 16;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int RANDOM_NUMBERS = 357;

    localparam logic [7:0] SELECT_NONE = 8'hF0;

    // idling regime that a number is sent under
    typedef enum logic [1:0] {
        PH_SLOW_SINK,
        PH_SLOW_SOURCE,
        PH_FREE
    } t_load_phase;

    // one serial beat as seen on the output channel
    typedef struct packed {
        logic       serial_bit;
        logic [1:0] digit_position;
        logic       frame_end;
        logic       last;
    } t_seg_beat;

    // one number waiting to be sent
    typedef struct {
        logic [ssw_pkg::NUM_W-1:0] number;
        t_load_phase               phase;
        bit                        wait_idle;
    } t_number_req;

    logic                      i_clk;
    logic                      i_rst_n          = 1'b0;
    logic                      i_valid          = 1'b0;
    logic                      o_stall;
    logic [ssw_pkg::NUM_W-1:0] i_number         = '0;
    logic                      o_valid;
    logic                      i_stall          = 1'b0;
    logic                      o_serial_bit;
    logic [1:0]                o_digit_position;
    logic                      o_frame_end;
    logic                      o_last;

    // active-low segment bytes for digits 0 to 9, select bytes for positions 0 to 3
    logic [7:0] segment_byte [0:9] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                       8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
    logic [7:0] select_byte  [0:3] = '{8'hF1, 8'hF2, 8'hF4, 8'hF8};

    t_number_req number_queue [$];
    t_seg_beat   expected_beats [$];
    t_load_phase phase        = PH_SLOW_SINK;
    logic        outputs_idle = 1'b1;
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;

    seven_segment_serial_writer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_number         (i_number),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_serial_bit     (o_serial_bit),
        .o_digit_position (o_digit_position),
        .o_frame_end      (o_frame_end),
        .o_last           (o_last)
    );

    // percentage of cycles a side idles in a given regime
    function automatic int unsigned idle_pct(input t_load_phase ph, input bit at_sink);
        case (ph)
            PH_SLOW_SINK:   return at_sink ? 82 : 17;
            PH_SLOW_SOURCE: return at_sink ? 17 : 82;
            default:        return 0;
        endcase
    endfunction

    // split a number into digits, lowest first, and queue one frame per digit
    task automatic queue_digit_frames(input logic [ssw_pkg::NUM_W-1:0] number);
        logic [ssw_pkg::NUM_W-1:0] remaining;
        logic [3:0]                digit;
        logic [7:0]                select;
        logic [15:0]               frame;
        t_seg_beat                 beat;
        int                        pos;
        bit                        more;
        remaining = number;
        pos       = DISPLAY_DIGITS - 1;
        more      = 1'b1;
        while (more && pos >= 0) begin
            digit     = 4'(remaining % 10);
            remaining = remaining / 10;
            more      = (remaining != 0) && (pos > 0);
            select    = (pos < 4) ? select_byte[pos] : SELECT_NONE;
            frame     = {segment_byte[digit], select};
            // msb first, strobe on the last bit of the frame
            for (int b = FRAME_BITS - 1; b >= 0; b--) begin
                beat.serial_bit     = frame[b];
                beat.digit_position = 2'(pos);
                beat.frame_end      = (b == 0);
                beat.last           = (b == 0) && !more;
                expected_beats.push_back(beat);
            end
            pos--;
        end
    endtask

    task automatic queue_number(input logic [ssw_pkg::NUM_W-1:0] number,
                                input t_load_phase ph, input bit wait_idle);
        t_number_req req;
        req.number    = number;
        req.phase     = ph;
        req.wait_idle = wait_idle;
        number_queue.push_back(req);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // input driver: presents queued numbers, holds the payload while stalled
    always @(posedge i_clk) begin : feed
        bit hold;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            hold = number_queue.size() == 0 ||
                   (number_queue[0].wait_idle && (i_valid || !outputs_idle));
            if (!hold && $urandom_range(99) >= idle_pct(number_queue[0].phase, 1'b0)) begin
                i_valid  <= 1'b1;
                i_number <= number_queue[0].number;
                phase    <= number_queue[0].phase;
                void'(number_queue.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: checks output beats, predicts on accepted numbers, drives stall
    always @(posedge i_clk) begin : check
        t_seg_beat want;
        if (!i_rst_n) begin
            i_stall      <= 1'b0;
            outputs_idle <= 1'b1;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_beats.size() == 0) begin
                    $error("beat with none expected: bit %0b pos %0d end %0b last %0b",
                           o_serial_bit, o_digit_position, o_frame_end, o_last);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (o_serial_bit !== want.serial_bit) begin
                        $error("serial_bit: expected %0b, got %0b",
                               want.serial_bit, o_serial_bit);
                        fail_count++;
                    end
                    if (o_digit_position !== want.digit_position) begin
                        $error("digit_position: expected %0d, got %0d",
                               want.digit_position, o_digit_position);
                        fail_count++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, o_frame_end);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall)
                queue_digit_frames(i_number);
            i_stall      <= ($urandom_range(99) < idle_pct(phase, 1'b1));
            outputs_idle <= (expected_beats.size() == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [ssw_pkg::NUM_W-1:0] n;
        t_load_phase               ph;

        // directed: zero, single digits, digit count edges, dropped high digits
        queue_number(32'd0,          PH_SLOW_SINK, 1'b1);
        queue_number(32'd1,          PH_SLOW_SINK, 1'b0);
        queue_number(32'd9,          PH_SLOW_SINK, 1'b0);
        queue_number(32'd10,         PH_SLOW_SINK, 1'b0);
        queue_number(32'd42,         PH_SLOW_SINK, 1'b1);
        queue_number(32'd99,         PH_SLOW_SINK, 1'b0);
        queue_number(32'd100,        PH_SLOW_SINK, 1'b0);
        queue_number(32'd305,        PH_SLOW_SINK, 1'b0);
        queue_number(32'd999,        PH_SLOW_SINK, 1'b0);
        queue_number(32'd1000,       PH_SLOW_SINK, 1'b0);
        queue_number(32'd1234,       PH_SLOW_SINK, 1'b0);
        queue_number(32'd5678,       PH_SLOW_SINK, 1'b0);
        queue_number(32'd9999,       PH_SLOW_SINK, 1'b0);
        queue_number(32'd10000,      PH_SLOW_SINK, 1'b1);
        queue_number(32'd90817,      PH_SLOW_SINK, 1'b0);
        queue_number(32'd1000000,    PH_SLOW_SINK, 1'b0);
        queue_number(32'd12345678,   PH_SLOW_SINK, 1'b0);
        queue_number(32'hFFFFFFFF,   PH_SLOW_SINK, 1'b0);
        queue_number(32'h80000000,   PH_SLOW_SINK, 1'b0);
        queue_number(32'd1234567890, PH_SLOW_SINK, 1'b0);
        queue_number(32'd4000000000, PH_SLOW_SINK, 1'b0);
        queue_number(32'd7,          PH_SLOW_SINK, 1'b0);
        queue_number(32'd60,         PH_SLOW_SINK, 1'b0);

        // random: mixed digit counts, trailing zeros, full-width values
        for (int i = 0; i < RANDOM_NUMBERS; i++) begin
            ph = (i < 130) ? PH_SLOW_SINK : (i < 260) ? PH_SLOW_SOURCE : PH_FREE;
            case ($urandom_range(9))
                0, 1, 2: n = $urandom;
                3:       n = $urandom_range(9);
                4, 5:    n = $urandom_range(9999, 10);
                6:       n = $urandom_range(99);
                7: begin
                    n = 1;
                    repeat ($urandom_range(9)) n = n * 10;
                    if ($urandom_range(1) != 0)
                        n = n - 1;
                end
                8:       n = $urandom_range(429495, 1) * 10000;
                default: n = {($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            endcase
            queue_number(n, ph, (i == 0 || i == 130 || i == 260 || $urandom_range(49) == 0));
        end

        // reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the last number to be taken and all of its beats to leave
        do @(negedge i_clk);
        while (number_queue.size() != 0 || i_valid || !outputs_idle);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_beats.size() != 0) begin
            $error("%0d expected beats never arrived", expected_beats.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
